[rtl/rsqr_pkg.sv]
// Shared types, constants and helper functions for the rotor sandwich
// quantise round-trip block. No dependencies; used by every rtl/ file.
package rsqr_pkg;

    // Store sizes
    localparam int GROUPS = 256;
    localparam int LEVELS = 16;
    localparam int ROT_AW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CB_AW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int QCNT_W = $clog2(LEVELS + 2);

    // Datapath widths: Q4.11 values, Q1.14 rotor words
    localparam int VAL_W  = 16;
    localparam int ROT_W  = 16;
    localparam int SRC_W  = 34;
    localparam int PROD_W = SRC_W + ROT_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int RND_SH = 28;

    // Input actions
    localparam logic [1:0] ACT_PROCESS  = 2'd0;
    localparam logic [1:0] ACT_ROTOR    = 2'd1;
    localparam logic [1:0] ACT_CODEBOOK = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCALAR_LEVELS    = 3'd0;
    localparam logic [2:0] CFG_VECTOR_LEVELS    = 3'd1;
    localparam logic [2:0] CFG_BIVECTOR_LEVELS  = 3'd2;
    localparam logic [2:0] CFG_TRIVECTOR_LEVELS = 3'd3;
    localparam logic [2:0] CFG_QUANT_ALL        = 3'd4;
    localparam logic [2:0] CFG_EMB_LENGTH       = 3'd5;

    typedef struct packed {
        logic [1:0]              action;
        logic [7:0]              group_index;
        logic [1:0]              table_select;
        logic [3:0]              entry_index;
        logic signed [15:0]      value_0;
        logic signed [15:0]      value_1;
        logic signed [15:0]      value_2;
        logic signed [15:0]      rotor_scalar;
        logic signed [15:0]      rotor_e12;
        logic signed [15:0]      rotor_e13;
        logic signed [15:0]      rotor_e23;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_0;
        logic signed [15:0] out_1;
        logic signed [15:0] out_2;
        logic [1:0]         valid_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD_A,
        ST_FWD_B,
        ST_QUANT,
        ST_INV_A,
        ST_INV_B,
        ST_DONE
    } state_t;

    // Lane multiply-accumulate control
    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } mac_ctl_t;

    // Lane codebook search control
    typedef struct packed {
        logic load;
        logic cmp_en;
    } quant_ctl_t;

    // Geometric product term map: output component k, term j uses rotor word j
    // (s, e12, e13, e23) times source component TERM_IDX[k][j].
    localparam logic [2:0] TERM_IDX [0:7][0:3] = '{
        '{3'd0, 3'd4, 3'd5, 3'd6},
        '{3'd1, 3'd2, 3'd3, 3'd7},
        '{3'd2, 3'd1, 3'd7, 3'd3},
        '{3'd3, 3'd7, 3'd1, 3'd2},
        '{3'd4, 3'd0, 3'd6, 3'd5},
        '{3'd5, 3'd6, 3'd0, 3'd4},
        '{3'd6, 3'd5, 3'd4, 3'd0},
        '{3'd7, 3'd3, 3'd2, 3'd1}
    };

    // Term signs (bit j set = subtract) for R*x and x*R
    localparam logic [3:0] LEFT_NEG [0:7] = '{
        4'b1110, 4'b0000, 4'b0110, 4'b1100,
        4'b1000, 4'b0010, 4'b0100, 4'b1010
    };
    localparam logic [3:0] RIGHT_NEG [0:7] = '{
        4'b1110, 4'b0110, 4'b1100, 4'b0000,
        4'b0100, 4'b1000, 4'b0010, 4'b0100
    };

    // Codebook (grade) of each component
    localparam logic [1:0] GRADE_OF [0:7] = '{
        2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3
    };

    // Round half up from 2^-39 to Q4.11 and saturate
    function automatic logic signed [VAL_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W:0]        sum;
        logic signed [ACC_W-RND_SH:0] sh;
        begin
            sum = {v[ACC_W-1], v} + (ACC_W+1)'(1 << (RND_SH - 1));
            sh  = sum[ACC_W:RND_SH];
            if (sh > (ACC_W-RND_SH+1)'(32767)) begin
                round_sat = 16'sh7FFF;
            end else if (sh < -(ACC_W-RND_SH+1)'(32768)) begin
                round_sat = -16'sh8000;
            end else begin
                round_sat = sh[VAL_W-1:0];
            end
        end
    endfunction

    // Clamp a levels register to 1..LEVELS
    function automatic logic [LVL_W-1:0] eff_levels(input logic [4:0] n);
        begin
            if (n == 5'd0) begin
                eff_levels = LVL_W'(1);
            end else if (32'(n) > LEVELS) begin
                eff_levels = LVL_W'(LEVELS);
            end else begin
                eff_levels = LVL_W'(n);
            end
        end
    endfunction

endpackage

[rtl/rsqr_mac_lane.sv]
// One multiply-accumulate lane: a component of a geometric product, term by term.
// Depends on rsqr_pkg.
module rsqr_mac_lane (
    input  logic                                aclk,
    input  rsqr_pkg::mac_ctl_t                  ctl,
    input  logic signed [rsqr_pkg::SRC_W-1:0]   operand,
    input  logic signed [rsqr_pkg::ROT_W-1:0]   coef,
    input  logic                                sub,
    output logic signed [rsqr_pkg::ACC_W-1:0]   acc_out,
    output logic signed [rsqr_pkg::VAL_W-1:0]   rnd_out
);

    logic signed [rsqr_pkg::PROD_W-1:0] prod_reg;
    logic                               sub_reg;
    logic signed [rsqr_pkg::ACC_W-1:0]  acc_reg;
    logic signed [rsqr_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = rsqr_pkg::ACC_W'(prod_reg);

    // Product register, then signed accumulate
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= operand * coef;
            sub_reg  <= sub;
        end
        if (ctl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    assign acc_out = acc_reg;
    assign rnd_out = rsqr_pkg::round_sat(acc_reg);

endmodule

[rtl/rsqr_quant_lane.sv]
// One codebook search lane: nearest centroid, first index wins a tie.
// Depends on rsqr_pkg.
module rsqr_quant_lane (
    input  logic                                aclk,
    input  rsqr_pkg::quant_ctl_t                ctl,
    input  logic signed [rsqr_pkg::VAL_W-1:0]   value_in,
    input  logic [rsqr_pkg::CB_AW-1:0]          idx,
    input  logic [rsqr_pkg::LVL_W-1:0]          nlev,
    input  logic signed [rsqr_pkg::VAL_W-1:0]   centroid,
    output logic signed [rsqr_pkg::VAL_W-1:0]   best_out
);

    logic signed [rsqr_pkg::VAL_W-1:0] val_reg;
    logic signed [rsqr_pkg::VAL_W-1:0] best_reg;
    logic [rsqr_pkg::VAL_W:0]          bd_reg;
    logic signed [rsqr_pkg::VAL_W:0]   diff;
    logic [rsqr_pkg::VAL_W:0]          absd;
    logic                              take;

    // Distance to the centroid now presented
    always_comb begin
        diff = rsqr_pkg::VAL_W'(1) == 0 ? '0 :
               ({val_reg[rsqr_pkg::VAL_W-1], val_reg}
                - {centroid[rsqr_pkg::VAL_W-1], centroid});
        absd = diff[rsqr_pkg::VAL_W] ? (rsqr_pkg::VAL_W+1)'(-diff)
                                     : (rsqr_pkg::VAL_W+1)'(diff);
        take = ctl.cmp_en && (rsqr_pkg::LVL_W'(idx) < nlev)
               && ((idx == '0) || (absd < bd_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            val_reg <= value_in;
        end
        if (take) begin
            best_reg <= centroid;
            bd_reg   <= absd;
        end
    end

    assign best_out = best_reg;

endmodule

[rtl/rotor_sandwich_quantize_roundtrip.sv]
// Top level: tables, configuration, sequencer, eight MAC and eight search lanes,
// and the merging stage. Depends on rsqr_pkg, rsqr_mac_lane, rsqr_quant_lane.
//
//  channel  ports                                    direction  carries
//  s_       s_valid  s_ready  s_data (in_item_t)     in         one group or table write
//  m_       m_valid  m_ready  m_data (out_item_t)    out        one result per input
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data    in         register write
//
// A group runs four product passes on the lane multipliers, one codebook
// sweep over the single read port of each codebook, and a done state, then
// returns to idle. Table writes and rejected items go straight to the done
// state and give a zero result. One item is in flight at a time; the result
// register lets it wait for m_ready, and the done state stalls while that
// register is full and m_ready is low.
// Reset is synchronous, active low; it clears control state and sets the
// configuration registers to their defaults. Tables hold nothing defined
// after reset until written.
module rotor_sandwich_quantize_roundtrip (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsqr_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rsqr_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [9:0]           cfg_data
);

    localparam int NL = 8;

    // Control state
    rsqr_pkg::state_t                state_reg, state_next;
    logic [2:0]                      step_reg, step_next;
    logic [rsqr_pkg::QCNT_W-1:0]     qcnt_reg, qcnt_next;
    logic                            m_valid_reg;

    // Configuration registers
    logic [4:0]                      lvl_reg [4];
    logic                            qall_reg;
    logic [9:0]                      emb_len_reg;

    // Tables
    logic [4*rsqr_pkg::ROT_W-1:0]    rot_mem [rsqr_pkg::GROUPS];
    logic [4*rsqr_pkg::ROT_W-1:0]    rot_rd_reg;
    logic signed [rsqr_pkg::VAL_W-1:0] cb_mem [4][rsqr_pkg::LEVELS];
    logic signed [rsqr_pkg::VAL_W-1:0] cb_rd_reg [4];

    // Item payload
    logic signed [rsqr_pkg::SRC_W-1:0] src_reg [NL];
    logic [2:0]                      mask_reg;
    logic [1:0]                      nv_reg;
    logic                            zero_reg;
    rsqr_pkg::out_item_t             res_reg;

    // Lane signals
    rsqr_pkg::mac_ctl_t              mac_ctl;
    rsqr_pkg::quant_ctl_t            q_ctl;
    logic signed [rsqr_pkg::SRC_W-1:0] lane_op [NL];
    logic                            lane_sub [NL];
    logic signed [rsqr_pkg::ACC_W-1:0] lane_acc [NL];
    logic signed [rsqr_pkg::VAL_W-1:0] lane_rnd [NL];
    logic signed [rsqr_pkg::VAL_W-1:0] lane_best [NL];
    logic [rsqr_pkg::LVL_W-1:0]      nlev [4];
    logic signed [rsqr_pkg::ROT_W-1:0] coef;
    logic [1:0]                      term;
    logic                            right_side, conj;
    logic [rsqr_pkg::QCNT_W-1:0]     qm1;
    logic [rsqr_pkg::CB_AW-1:0]      q_idx;

    // Accept-side decode
    logic                            s_fire, out_free, g_ok, is_proc;
    logic [10:0]                     base;
    logic [2:0]                      elem_ok;
    logic signed [rsqr_pkg::VAL_W-1:0] in_val [3];
    logic                            mac_last, q_last;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign g_ok     = 32'(s_data.group_index) < rsqr_pkg::GROUPS;
    assign is_proc  = (s_data.action == rsqr_pkg::ACT_PROCESS) && g_ok;
    assign base     = 11'(s_data.group_index) * 11'd3;
    assign in_val[0] = s_data.value_0;
    assign in_val[1] = s_data.value_1;
    assign in_val[2] = s_data.value_2;
    assign mac_last = (step_reg == 3'd5);
    assign q_last   = (qcnt_reg == rsqr_pkg::QCNT_W'(rsqr_pkg::LEVELS + 1));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            elem_ok[k] = (base + 11'(k)) < {1'b0, emb_len_reg};
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        qcnt_next  = qcnt_reg;
        case (state_reg)
            rsqr_pkg::ST_IDLE: begin
                step_next = 3'd0;
                if (s_fire) begin
                    state_next = is_proc ? rsqr_pkg::ST_FWD_A : rsqr_pkg::ST_DONE;
                end
            end
            rsqr_pkg::ST_FWD_A, rsqr_pkg::ST_FWD_B,
            rsqr_pkg::ST_INV_A, rsqr_pkg::ST_INV_B: begin
                step_next = mac_last ? 3'd0 : step_reg + 3'd1;
                qcnt_next = '0;
                if (mac_last) begin
                    case (state_reg)
                        rsqr_pkg::ST_FWD_A: state_next = rsqr_pkg::ST_FWD_B;
                        rsqr_pkg::ST_FWD_B: state_next = rsqr_pkg::ST_QUANT;
                        rsqr_pkg::ST_INV_A: state_next = rsqr_pkg::ST_INV_B;
                        default:            state_next = rsqr_pkg::ST_DONE;
                    endcase
                end
            end
            rsqr_pkg::ST_QUANT: begin
                qcnt_next = qcnt_reg + rsqr_pkg::QCNT_W'(1);
                if (q_last) begin
                    state_next = rsqr_pkg::ST_INV_A;
                    qcnt_next  = '0;
                end
            end
            rsqr_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rsqr_pkg::ST_IDLE;
                end
            end
            default: state_next = rsqr_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready    = 1'b0;
        mac_ctl    = '0;
        q_ctl      = '0;
        right_side = 1'b0;
        conj       = 1'b0;
        case (state_reg)
            rsqr_pkg::ST_IDLE: s_ready = 1'b1;
            rsqr_pkg::ST_FWD_A, rsqr_pkg::ST_FWD_B,
            rsqr_pkg::ST_INV_A, rsqr_pkg::ST_INV_B: begin
                mac_ctl.mul_en  = (step_reg < 3'd4);
                mac_ctl.acc_clr = (step_reg == 3'd0);
                mac_ctl.acc_en  = (step_reg != 3'd0) && (step_reg < 3'd5);
                right_side = (state_reg == rsqr_pkg::ST_FWD_B)
                          || (state_reg == rsqr_pkg::ST_INV_B);
                conj       = (state_reg == rsqr_pkg::ST_FWD_B)
                          || (state_reg == rsqr_pkg::ST_INV_A);
                q_ctl.load = (state_reg == rsqr_pkg::ST_FWD_B) && mac_last;
            end
            rsqr_pkg::ST_QUANT: begin
                q_ctl.cmp_en = (qcnt_reg != '0)
                            && (qcnt_reg <= rsqr_pkg::QCNT_W'(rsqr_pkg::LEVELS));
            end
            default: ;
        endcase
    end

    // Lane operand selection
    assign term = step_reg[1:0];
    assign coef = rot_rd_reg[rsqr_pkg::ROT_W*term +: rsqr_pkg::ROT_W];
    assign qm1  = qcnt_reg - rsqr_pkg::QCNT_W'(1);
    assign q_idx = qm1[rsqr_pkg::CB_AW-1:0];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            lane_op[k]  = src_reg[rsqr_pkg::TERM_IDX[k][term]];
            lane_sub[k] = (right_side ? rsqr_pkg::RIGHT_NEG[k][term]
                                      : rsqr_pkg::LEFT_NEG[k][term])
                          ^ (conj && (term != 2'd0));
        end
        for (int g = 0; g < 4; g++) begin
            nlev[g] = rsqr_pkg::eff_levels(lvl_reg[g]);
        end
    end

    // Lanes
    for (genvar k = 0; k < NL; k++) begin : g_lane
        rsqr_mac_lane u_mac (
            .aclk    (aclk),
            .ctl     (mac_ctl),
            .operand (lane_op[k]),
            .coef    (coef),
            .sub     (lane_sub[k]),
            .acc_out (lane_acc[k]),
            .rnd_out (lane_rnd[k])
        );
        rsqr_quant_lane u_quant (
            .aclk     (aclk),
            .ctl      (q_ctl),
            .value_in (lane_rnd[k]),
            .idx      (q_idx),
            .nlev     (nlev[rsqr_pkg::GRADE_OF[k]]),
            .centroid (cb_rd_reg[rsqr_pkg::GRADE_OF[k]]),
            .best_out (lane_best[k])
        );
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsqr_pkg::ST_IDLE;
            step_reg    <= 3'd0;
            qcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
            lvl_reg[0]  <= 5'd16;
            lvl_reg[1]  <= 5'd16;
            lvl_reg[2]  <= 5'd16;
            lvl_reg[3]  <= 5'd16;
            qall_reg    <= 1'b1;
            emb_len_reg <= 10'd768;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            qcnt_reg  <= qcnt_next;
            if ((state_reg == rsqr_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    rsqr_pkg::CFG_SCALAR_LEVELS:    lvl_reg[0]  <= cfg_data[4:0];
                    rsqr_pkg::CFG_VECTOR_LEVELS:    lvl_reg[1]  <= cfg_data[4:0];
                    rsqr_pkg::CFG_BIVECTOR_LEVELS:  lvl_reg[2]  <= cfg_data[4:0];
                    rsqr_pkg::CFG_TRIVECTOR_LEVELS: lvl_reg[3]  <= cfg_data[4:0];
                    rsqr_pkg::CFG_QUANT_ALL:        qall_reg    <= cfg_data[0];
                    rsqr_pkg::CFG_EMB_LENGTH:       emb_len_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Rotor and codebook tables
    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.action == rsqr_pkg::ACT_ROTOR) && g_ok) begin
            rot_mem[rsqr_pkg::ROT_AW'(s_data.group_index)] <=
                {s_data.rotor_e23, s_data.rotor_e13, s_data.rotor_e12,
                 s_data.rotor_scalar};
        end
        if (s_fire) begin
            rot_rd_reg <= rot_mem[rsqr_pkg::ROT_AW'(s_data.group_index)];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_data.action == rsqr_pkg::ACT_CODEBOOK)
            && (32'(s_data.entry_index) < rsqr_pkg::LEVELS)) begin
            cb_mem[s_data.table_select][rsqr_pkg::CB_AW'(s_data.entry_index)]
                <= s_data.value_0;
        end
        for (int g = 0; g < 4; g++) begin
            cb_rd_reg[g] <= cb_mem[g][qcnt_reg[rsqr_pkg::CB_AW-1:0]];
        end
    end

    // Item payload and merging stage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            zero_reg <= !is_proc;
            mask_reg <= elem_ok;
            nv_reg   <= 2'(elem_ok[0]) + 2'(elem_ok[1]) + 2'(elem_ok[2]);
            // vector part carries the group, all other components start at zero
            src_reg[0] <= '0;
            for (int k = 0; k < 3; k++) begin
                src_reg[k+1] <= elem_ok[k] ? rsqr_pkg::SRC_W'(in_val[k]) : '0;
            end
            for (int k = 4; k < NL; k++) begin
                src_reg[k] <= '0;
            end
        end
        if (((state_reg == rsqr_pkg::ST_FWD_A) || (state_reg == rsqr_pkg::ST_INV_A))
            && mac_last) begin
            for (int k = 0; k < NL; k++) begin
                src_reg[k] <= lane_acc[k][rsqr_pkg::SRC_W-1:0];
            end
        end
        if ((state_reg == rsqr_pkg::ST_QUANT) && q_last) begin
            for (int k = 0; k < NL; k++) begin
                if ((rsqr_pkg::GRADE_OF[k] == 2'd1) || (rsqr_pkg::GRADE_OF[k] == 2'd3)
                    || qall_reg) begin
                    src_reg[k] <= rsqr_pkg::SRC_W'(lane_best[k]);
                end else begin
                    src_reg[k] <= '0;
                end
            end
        end
        if ((state_reg == rsqr_pkg::ST_INV_B) && mac_last) begin
            res_reg.out_0       <= mask_reg[0] ? lane_rnd[1] : '0;
            res_reg.out_1       <= mask_reg[1] ? lane_rnd[2] : '0;
            res_reg.out_2       <= mask_reg[2] ? lane_rnd[3] : '0;
            res_reg.valid_count <= nv_reg;
        end
        if ((state_reg == rsqr_pkg::ST_DONE) && out_free) begin
            m_data <= zero_reg ? '0 : res_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

    // Checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("second item taken while one is in flight");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 3'd5)
        else $error("product pass step out of range");

    a_qcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsqr_pkg::ST_QUANT) |->
            (qcnt_reg <= rsqr_pkg::QCNT_W'(rsqr_pkg::LEVELS + 1)))
        else $error("codebook sweep overran");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == rsqr_pkg::ST_DONE))
        else $error("result raised outside the done state");

endmodule
